/* design/tsvu_pkg.sv */
// Shared types and constants for the tab-separated field unescaper.
`default_nettype none
package tsvu_pkg;

  // Escape decoder mode
  typedef enum logic [1:0] {
    ESC_NORMAL      = 2'd0,
    ESC_AFTER_BSL   = 2'd1,
    ESC_BRACE_START = 2'd2,
    ESC_BRACE_NUM   = 2'd3
  } esc_mode_t;

  // Where we are with respect to a possible \N null marker
  typedef enum logic [1:0] {
    POS_START  = 2'd0,
    POS_BSL    = 2'd1,
    POS_LOCKED = 2'd2
  } field_pos_t;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Output queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       field_null;
    logic       field_invalid;
    logic       row_done;
    logic       row_invalid;
  } result_t;

  // Results produced by one input byte (up to two)
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } result_pair_t;

endpackage
`default_nettype wire

/* design/tsvu_decode.sv */
// Escape decoder: field state registers and per-byte result generation.
`default_nettype none
module tsvu_decode (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  end_of_row,
  output tsvu_pkg::result_pair_t     results
);

  tsvu_pkg::esc_mode_t  escape_mode, escape_mode_next;
  tsvu_pkg::field_pos_t field_position, field_position_next;
  logic       null_skip, null_skip_next;
  logic [7:0] brace_value, brace_value_next;
  logic       brace_negative, brace_negative_next;
  logic       brace_parse_stopped, brace_parse_stopped_next;
  logic       invalid_seen, invalid_seen_next;

  logic       sep;
  logic       digit;
  logic       fld_inv;
  logic       last;
  logic       inv_seen_mid;
  logic [1:0] n;
  tsvu_pkg::result_t data_res;
  tsvu_pkg::result_t mark0;
  tsvu_pkg::result_t mark1;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode         <= tsvu_pkg::ESC_NORMAL;
      field_position      <= tsvu_pkg::POS_START;
      null_skip           <= 1'b0;
      brace_value         <= '0;
      brace_negative      <= 1'b0;
      brace_parse_stopped <= 1'b0;
      invalid_seen        <= 1'b0;
    end else if (fire) begin
      escape_mode         <= escape_mode_next;
      field_position      <= field_position_next;
      null_skip           <= null_skip_next;
      brace_value         <= brace_value_next;
      brace_negative      <= brace_negative_next;
      brace_parse_stopped <= brace_parse_stopped_next;
      invalid_seen        <= invalid_seen_next;
    end
  end

  // Byte decode, then field/row end handling
  always_comb begin
    escape_mode_next         = escape_mode;
    field_position_next      = field_position;
    null_skip_next           = null_skip;
    brace_value_next         = brace_value;
    brace_negative_next      = brace_negative;
    brace_parse_stopped_next = brace_parse_stopped;
    invalid_seen_next        = invalid_seen;
    n        = 2'd0;
    data_res = '0;
    data_res.kind = tsvu_pkg::KIND_DATA;
    mark0    = '0;
    mark1    = '0;
    results  = '0;

    sep   = (in_byte == tsvu_pkg::CH_TAB) || (in_byte == tsvu_pkg::CH_CR) ||
            (in_byte == tsvu_pkg::CH_LF);
    digit = (in_byte >= tsvu_pkg::CH_ZERO) && (in_byte <= tsvu_pkg::CH_NINE);

    if (!sep && !null_skip) begin
      case (escape_mode)
        tsvu_pkg::ESC_NORMAL: begin
          if (in_byte == tsvu_pkg::CH_BSL) begin
            escape_mode_next    = tsvu_pkg::ESC_AFTER_BSL;
            field_position_next = (field_position == tsvu_pkg::POS_START) ?
                                  tsvu_pkg::POS_BSL : tsvu_pkg::POS_LOCKED;
          end else begin
            field_position_next = tsvu_pkg::POS_LOCKED;
            data_res.data_byte  = in_byte;
            n = 2'd1;
          end
        end
        tsvu_pkg::ESC_AFTER_BSL: begin
          escape_mode_next    = tsvu_pkg::ESC_NORMAL;
          field_position_next = tsvu_pkg::POS_LOCKED;
          if (field_position == tsvu_pkg::POS_BSL && in_byte == tsvu_pkg::CH_UPPER_N) begin
            null_skip_next = 1'b1;
          end else if (in_byte == tsvu_pkg::CH_LOWER_T) begin
            data_res.data_byte = tsvu_pkg::CH_TAB;
            n = 2'd1;
          end else if (in_byte == tsvu_pkg::CH_LOWER_R) begin
            data_res.data_byte = tsvu_pkg::CH_CR;
            n = 2'd1;
          end else if (in_byte == tsvu_pkg::CH_LOWER_N) begin
            data_res.data_byte = tsvu_pkg::CH_LF;
            n = 2'd1;
          end else if (in_byte == tsvu_pkg::CH_LBRACE) begin
            escape_mode_next         = tsvu_pkg::ESC_BRACE_START;
            brace_value_next         = '0;
            brace_negative_next      = 1'b0;
            brace_parse_stopped_next = 1'b0;
          end else begin
            data_res.data_byte = in_byte;
            n = 2'd1;
          end
        end
        default: begin
          // inside \{...}
          if (in_byte == tsvu_pkg::CH_RBRACE) begin
            data_res.data_byte = brace_negative ? (8'd0 - brace_value) : brace_value;
            n = 2'd1;
            escape_mode_next         = tsvu_pkg::ESC_NORMAL;
            brace_value_next         = '0;
            brace_negative_next      = 1'b0;
            brace_parse_stopped_next = 1'b0;
          end else if (brace_parse_stopped) begin
            // skip to closing brace
          end else if (digit) begin
            brace_value_next = (brace_value << 3) + (brace_value << 1) +
                               (in_byte - tsvu_pkg::CH_ZERO);
            escape_mode_next = tsvu_pkg::ESC_BRACE_NUM;
          end else if (escape_mode == tsvu_pkg::ESC_BRACE_START &&
                       (in_byte == tsvu_pkg::CH_SPACE || in_byte == tsvu_pkg::CH_VT ||
                        in_byte == tsvu_pkg::CH_FF)) begin
            // leading white space
          end else if (escape_mode == tsvu_pkg::ESC_BRACE_START &&
                       (in_byte == tsvu_pkg::CH_MINUS || in_byte == tsvu_pkg::CH_PLUS)) begin
            brace_negative_next = (in_byte == tsvu_pkg::CH_MINUS);
            escape_mode_next    = tsvu_pkg::ESC_BRACE_NUM;
          end else begin
            brace_parse_stopped_next = 1'b1;
          end
        end
      endcase
    end

    // Field end markers
    fld_inv      = !null_skip_next && (escape_mode_next != tsvu_pkg::ESC_NORMAL);
    last         = end_of_row && !sep;
    inv_seen_mid = invalid_seen | fld_inv;

    mark0.kind          = tsvu_pkg::KIND_MARKER;
    mark0.field_null    = null_skip_next;
    mark0.field_invalid = fld_inv;
    mark0.row_done      = last;
    mark0.row_invalid   = last & inv_seen_mid;

    mark1.kind          = tsvu_pkg::KIND_MARKER;
    mark1.row_done      = 1'b1;
    mark1.row_invalid   = inv_seen_mid;

    results.res0 = data_res;
    results.count = n;
    if (sep || end_of_row) begin
      invalid_seen_next        = end_of_row ? 1'b0 : inv_seen_mid;
      escape_mode_next         = tsvu_pkg::ESC_NORMAL;
      field_position_next      = tsvu_pkg::POS_START;
      null_skip_next           = 1'b0;
      brace_value_next         = '0;
      brace_negative_next      = 1'b0;
      brace_parse_stopped_next = 1'b0;
      if (n == 2'd1) begin
        // data byte then final marker
        results.res1  = mark0;
        results.count = 2'd2;
      end else begin
        results.res0 = mark0;
        if (sep && end_of_row) begin
          results.res1  = mark1;
          results.count = 2'd2;
        end else begin
          results.count = 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/tsvu_out_queue.sv */
// Small result queue: takes up to two results a cycle, gives one per beat.
`default_nettype none
module tsvu_out_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire tsvu_pkg::result_pair_t push_data,
  output logic                        room2,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tsvu_pkg::result_t           head
);

  tsvu_pkg::result_t entries [tsvu_pkg::QDEPTH];
  logic [tsvu_pkg::QAW-1:0] rd_ptr, wr_ptr;
  logic [tsvu_pkg::QAW:0]   count, count_next;
  logic                     pop;
  logic [1:0]               n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign room2     = (count <= (tsvu_pkg::QAW+1)'(tsvu_pkg::QDEPTH - 2));
  assign n_push    = push ? push_data.count : 2'd0;

  always_comb begin
    count_next = count + (tsvu_pkg::QAW+1)'(n_push) - (tsvu_pkg::QAW+1)'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + tsvu_pkg::QAW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= push_data.res0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push_data.res1;
    end
  end

endmodule
`default_nettype wire

/* design/tsv_field_unescaper.sv */
// Top level of the tab-separated field unescaper.
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------
//  input   | in        | in_valid / in_ready  | in_byte, end_of_row
//  output  | out       | out_valid/ out_ready | kind, data_byte, field_null,
//          |           |                      | field_invalid, row_done, row_invalid
//
// One byte per cycle while the queue has room: it is held in an input register,
// decoded combinationally, and its zero to two results go to a four-entry queue.
// When the queue is empty, a first result is offered as soon as it is written.
// An input byte leaves its register only when the queue has room for two results,
// so a stalled output backs up into in_ready after a few beats.
// rst (synchronous) empties the register and queue and clears all field state.
`default_nettype none
module tsv_field_unescaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_row,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      data_byte,
  output logic            field_null,
  output logic            field_invalid,
  output logic            row_done,
  output logic            row_invalid
);

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_eor;
  logic       consume;
  logic       room2;
  tsvu_pkg::result_pair_t results;
  tsvu_pkg::result_t      head;

  assign consume  = stg_valid && room2;
  assign in_ready = !stg_valid || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte <= in_byte;
      stg_eor  <= end_of_row;
    end
  end

  tsvu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .fire       (consume),
    .in_byte    (stg_byte),
    .end_of_row (stg_eor),
    .results    (results)
  );

  tsvu_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (consume),
    .push_data (results),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind          = head.kind;
  assign data_byte     = head.data_byte;
  assign field_null    = head.field_null;
  assign field_invalid = head.field_invalid;
  assign row_done      = head.row_done;
  assign row_invalid   = head.row_invalid;

endmodule
`default_nettype wire

/* sim/tb_tsv_field_unescaper.sv */
// Self-checking testbench for the tab-separated field unescaper.
`timescale 1ns / 1ps
module tb_tsv_field_unescaper;

  localparam int RANDOM_BEATS = 1900;
  localparam int DRAIN_CYCLES = 20;
  localparam int PREDICT      = -1;   // result count meaning "ask the decoder model"
  localparam tsvu_pkg::result_t NO_RES = '0;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_row;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       field_null;
  logic       field_invalid;
  logic       row_done;
  logic       row_invalid;

  tsv_field_unescaper u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_row   (end_of_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .field_null   (field_null),
    .field_invalid(field_invalid),
    .row_done     (row_done),
    .row_invalid  (row_invalid)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Decoder model state
  tsvu_pkg::esc_mode_t  dec_mode       = tsvu_pkg::ESC_NORMAL;
  tsvu_pkg::field_pos_t dec_pos        = tsvu_pkg::POS_START;
  logic        dec_null_skip  = 1'b0;
  logic [7:0]  dec_brace_val  = 8'd0;
  logic        dec_brace_neg  = 1'b0;
  logic        dec_brace_stop = 1'b0;
  logic        dec_row_bad    = 1'b0;

  tsvu_pkg::result_t byte_results[$];     // results of the byte just decoded
  tsvu_pkg::result_t pending_results[$];  // results still owed by the block
  int          error_count = 0;
  int          beat_count  = 0;
  bit          tx_burst    = 1'b0;
  int          rx_left     = 0;
  logic        rx_level    = 1'b0;
  logic [7:0]  row_bytes[$];

  typedef struct {
    logic [7:0]        b;
    logic              eor;
    int                n;
    tsvu_pkg::result_t r0;
    tsvu_pkg::result_t r1;
  } dir_row_t;

  dir_row_t dir_rows[25];

  function automatic tsvu_pkg::result_t data_res(input logic [7:0] v);
    tsvu_pkg::result_t r;
    r           = '0;
    r.kind      = tsvu_pkg::KIND_DATA;
    r.data_byte = v;
    return r;
  endfunction

  function automatic tsvu_pkg::result_t marker_res(input logic nul, input logic inv,
                                                   input logic done, input logic rinv);
    tsvu_pkg::result_t r;
    r               = '0;
    r.kind          = tsvu_pkg::KIND_MARKER;
    r.field_null    = nul;
    r.field_invalid = inv;
    r.row_done      = done;
    r.row_invalid   = rinv;
    return r;
  endfunction

  // Queue appends
  function automatic void add_result(input tsvu_pkg::result_t r);
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void owe_result(input tsvu_pkg::result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row_byte(input logic [7:0] v);
    row_bytes.insert(row_bytes.size(), v);
  endfunction

  function automatic logic is_sep(input logic [7:0] v);
    return (v == tsvu_pkg::CH_TAB) || (v == tsvu_pkg::CH_CR) || (v == tsvu_pkg::CH_LF);
  endfunction

  function automatic void clear_brace();
    dec_brace_val  = 8'd0;
    dec_brace_neg  = 1'b0;
    dec_brace_stop = 1'b0;
  endfunction

  // Decode one byte; its results land in byte_results
  function automatic void decode_byte(input logic [7:0] b, input logic eor);
    logic sep, is_digit, inv, last;
    logic [7:0] v;
    sep      = is_sep(b);
    is_digit = (b >= tsvu_pkg::CH_ZERO) && (b <= tsvu_pkg::CH_NINE);
    byte_results.delete();

    if (!sep && !dec_null_skip) begin
      case (dec_mode)
        tsvu_pkg::ESC_NORMAL: begin
          if (b == tsvu_pkg::CH_BSL) begin
            dec_mode = tsvu_pkg::ESC_AFTER_BSL;
            if (dec_pos == tsvu_pkg::POS_START) dec_pos = tsvu_pkg::POS_BSL;
            else dec_pos = tsvu_pkg::POS_LOCKED;
          end else begin
            dec_pos = tsvu_pkg::POS_LOCKED;
            add_result(data_res(b));
          end
        end
        tsvu_pkg::ESC_AFTER_BSL: begin
          dec_mode = tsvu_pkg::ESC_NORMAL;
          if (dec_pos == tsvu_pkg::POS_BSL && b == tsvu_pkg::CH_UPPER_N) begin
            // field opens with backslash N: null, drop the rest
            dec_null_skip = 1'b1;
            dec_pos       = tsvu_pkg::POS_LOCKED;
          end else begin
            dec_pos = tsvu_pkg::POS_LOCKED;
            case (b)
              tsvu_pkg::CH_LOWER_T: add_result(data_res(tsvu_pkg::CH_TAB));
              tsvu_pkg::CH_LOWER_R: add_result(data_res(tsvu_pkg::CH_CR));
              tsvu_pkg::CH_LOWER_N: add_result(data_res(tsvu_pkg::CH_LF));
              tsvu_pkg::CH_LBRACE: begin
                dec_mode = tsvu_pkg::ESC_BRACE_START;
                clear_brace();
              end
              default:              add_result(data_res(b));
            endcase
          end
        end
        default: begin
          // inside a brace number
          if (b == tsvu_pkg::CH_RBRACE) begin
            v = dec_brace_neg ? 8'd0 - dec_brace_val : dec_brace_val;
            add_result(data_res(v));
            dec_mode = tsvu_pkg::ESC_NORMAL;
            clear_brace();
          end else if (dec_brace_stop) begin
            // junk up to the closing brace
          end else if (is_digit) begin
            dec_brace_val = dec_brace_val * 8'd10 + (b - tsvu_pkg::CH_ZERO);
            dec_mode      = tsvu_pkg::ESC_BRACE_NUM;
          end else if (dec_mode == tsvu_pkg::ESC_BRACE_START &&
                       (b == tsvu_pkg::CH_SPACE || b == tsvu_pkg::CH_VT ||
                        b == tsvu_pkg::CH_FF)) begin
            // leading white space
          end else if (dec_mode == tsvu_pkg::ESC_BRACE_START &&
                       (b == tsvu_pkg::CH_MINUS || b == tsvu_pkg::CH_PLUS)) begin
            dec_brace_neg = (b == tsvu_pkg::CH_MINUS);
            dec_mode      = tsvu_pkg::ESC_BRACE_NUM;
          end else begin
            dec_brace_stop = 1'b1;
          end
        end
      endcase
    end

    // field end, and the empty final field after a trailing separator
    if (sep || eor) begin
      inv  = !dec_null_skip && (dec_mode != tsvu_pkg::ESC_NORMAL);
      last = eor && !sep;
      if (inv) dec_row_bad = 1'b1;
      add_result(marker_res(dec_null_skip, inv, last, last && dec_row_bad));
      dec_mode      = tsvu_pkg::ESC_NORMAL;
      dec_pos       = tsvu_pkg::POS_START;
      dec_null_skip = 1'b0;
      clear_brace();
      if (sep && eor) add_result(marker_res(1'b0, 1'b0, 1'b1, dec_row_bad));
      if (eor) dec_row_bad = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 200)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Output side: compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    tsvu_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 200)
          $display("%0t: unexpected result beat, expected none, actual kind %0d data %h",
                   $time, kind, data_byte);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind));
        check_field("data_byte", want.data_byte, data_byte);
        check_field("field_null", 8'(want.field_null), 8'(field_null));
        check_field("field_invalid", 8'(want.field_invalid), 8'(field_invalid));
        check_field("row_done", 8'(want.row_done), 8'(row_done));
        check_field("row_invalid", 8'(want.row_invalid), 8'(row_invalid));
      end
    end
  end

  // Output ready: runs of random length, short stalls mostly, a few long ones
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      out_ready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          rx_level = 1'b1;
          rx_left  = $urandom_range(50, 150);
        end else if (pick < 50) begin
          rx_level = 1'b1;
          rx_left  = $urandom_range(1, 20);
        end else if (pick < 85) begin
          rx_level = 1'b0;
          rx_left  = $urandom_range(1, 3);
        end else if (pick < 97) begin
          rx_level = 1'b0;
          rx_left  = $urandom_range(4, 10);
        end else begin
          rx_level = 1'b0;
          rx_left  = $urandom_range(20, 40);
        end
      end
      rx_left = rx_left - 1;
      out_ready <= rx_level;
    end
  end

  // Hold the beat until the block takes it
  task automatic send_beat(input logic [7:0] b, input logic eor);
    in_valid   <= 1'b1;
    in_byte    <= b;
    end_of_row <= eor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beat_count++;
  endtask

  // Random gap after an accepted beat
  task automatic idle_gap();
    int pick, gap;
    pick = $urandom_range(0, 99);
    if (tx_burst || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result is out
  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do begin
      if ($urandom_range(0, 9) < 8) v = 8'($urandom_range(32, 126));
      else v = 8'($urandom_range(0, 255));
    end while (v == tsvu_pkg::CH_BSL || is_sep(v));
    return v;
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return tsvu_pkg::CH_TAB;
      1:       return tsvu_pkg::CH_CR;
      default: return tsvu_pkg::CH_LF;
    endcase
  endfunction

  // One row of mostly well-formed fields with random content
  task automatic build_row();
    int nfields, nseg, cnt;
    row_bytes.delete();
    nfields = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 6);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) add_row_byte(pick_sep());
      if ($urandom_range(0, 99) < 8) begin
        // null field with zero to three trailing bytes
        add_row_byte(tsvu_pkg::CH_BSL);
        add_row_byte(tsvu_pkg::CH_UPPER_N);
        cnt = $urandom_range(0, 3);
        repeat (cnt)
          add_row_byte($urandom_range(0, 5) == 0 ? tsvu_pkg::CH_BSL : plain_byte());
      end else begin
        nseg = $urandom_range(0, 3);
        repeat (nseg) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              cnt = $urandom_range(1, 5);
              repeat (cnt) add_row_byte(plain_byte());
            end
            4, 5: begin
              add_row_byte(tsvu_pkg::CH_BSL);
              case ($urandom_range(0, 3))
                0:       add_row_byte(tsvu_pkg::CH_LOWER_T);
                1:       add_row_byte(tsvu_pkg::CH_LOWER_R);
                2:       add_row_byte(tsvu_pkg::CH_LOWER_N);
                default:
                  add_row_byte($urandom_range(0, 3) == 0 ? tsvu_pkg::CH_BSL : plain_byte());
              endcase
            end
            6, 7: begin
              // brace number: white space, sign, digits, junk, close
              add_row_byte(tsvu_pkg::CH_BSL);
              add_row_byte(tsvu_pkg::CH_LBRACE);
              cnt = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
              repeat (cnt) begin
                case ($urandom_range(0, 2))
                  0:       add_row_byte(tsvu_pkg::CH_SPACE);
                  1:       add_row_byte(tsvu_pkg::CH_VT);
                  default: add_row_byte(tsvu_pkg::CH_FF);
                endcase
              end
              if ($urandom_range(0, 9) < 3)
                add_row_byte($urandom_range(0, 1) ? tsvu_pkg::CH_MINUS : tsvu_pkg::CH_PLUS);
              cnt = $urandom_range(0, 4);
              repeat (cnt) add_row_byte(tsvu_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
              if ($urandom_range(0, 9) < 2) begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) add_row_byte(plain_byte());
              end
              add_row_byte(tsvu_pkg::CH_RBRACE);
            end
            8: begin
              cnt = $urandom_range(1, 3);
              repeat (cnt) add_row_byte(8'($urandom_range(0, 255)));
            end
            default: begin
              add_row_byte(tsvu_pkg::CH_BSL);
              add_row_byte(tsvu_pkg::CH_UPPER_N);
            end
          endcase
        end
        // broken field end: dangling backslash or unclosed brace
        if ($urandom_range(0, 19) == 0) begin
          add_row_byte(tsvu_pkg::CH_BSL);
          if ($urandom_range(0, 1)) begin
            add_row_byte(tsvu_pkg::CH_LBRACE);
            cnt = $urandom_range(0, 2);
            repeat (cnt) add_row_byte(tsvu_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
      end
    end
    if ($urandom_range(0, 4) == 0) add_row_byte(pick_sep());
    if (row_bytes.size() == 0) add_row_byte(plain_byte());
  endtask

  // Stimulus
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_byte    <= 8'd0;
    end_of_row <= 1'b0;

    // byte, end of row, result count (or PREDICT), results
    dir_rows = '{
      '{8'h61,               1'b0, 1,       data_res(8'h61), NO_RES},
      '{8'h00,               1'b0, 1,       data_res(8'h00), NO_RES},
      '{8'hFF,               1'b0, 1,       data_res(8'hFF), NO_RES},
      '{tsvu_pkg::CH_TAB,     1'b0, 1,       marker_res(1'b0, 1'b0, 1'b0, 1'b0), NO_RES},
      '{tsvu_pkg::CH_BSL,     1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_UPPER_N, 1'b0, PREDICT, NO_RES,          NO_RES},
      '{8'h78,               1'b1, 1,       marker_res(1'b1, 1'b0, 1'b1, 1'b0), NO_RES},
      '{tsvu_pkg::CH_BSL,     1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_LOWER_T, 1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_BSL,     1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_LBRACE,  1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_MINUS,   1'b0, PREDICT, NO_RES,          NO_RES},
      '{8'h31,               1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_RBRACE,  1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_BSL,     1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_LBRACE,  1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_SPACE,   1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_NINE,    1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_NINE,    1'b0, PREDICT, NO_RES,          NO_RES},
      '{8'h7A,               1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_RBRACE,  1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_BSL,     1'b0, PREDICT, NO_RES,          NO_RES},
      '{tsvu_pkg::CH_LF,      1'b1, 2,       marker_res(1'b0, 1'b1, 1'b0, 1'b0),
                                            marker_res(1'b0, 1'b0, 1'b1, 1'b1)},
      '{tsvu_pkg::CH_BSL,     1'b1, 1,       marker_res(1'b0, 1'b1, 1'b1, 1'b1), NO_RES},
      '{tsvu_pkg::CH_LF,      1'b1, 2,       marker_res(1'b0, 1'b0, 1'b0, 1'b0),
                                            marker_res(1'b0, 1'b0, 1'b1, 1'b0)}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows; typed rows still step the model to keep its state
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].b, dir_rows[i].eor);
      decode_byte(dir_rows[i].b, dir_rows[i].eor);
      if (dir_rows[i].n == PREDICT) begin
        foreach (byte_results[k]) owe_result(byte_results[k]);
      end else begin
        if (dir_rows[i].n > 0) owe_result(dir_rows[i].r0);
        if (dir_rows[i].n > 1) owe_result(dir_rows[i].r1);
      end
      idle_gap();
    end
    drain_wait();

    // random rows
    while (beat_count < RANDOM_BEATS + 25) begin
      build_row();
      tx_burst = ($urandom_range(0, 9) == 0);
      foreach (row_bytes[i]) begin
        send_beat(row_bytes[i], i == row_bytes.size() - 1);
        decode_byte(row_bytes[i], i == row_bytes.size() - 1);
        foreach (byte_results[k]) owe_result(byte_results[k]);
        idle_gap();
      end
      if ($urandom_range(0, 39) == 0) drain_wait();
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/tsvu_pkg.sv
design/tsvu_decode.sv
design/tsvu_out_queue.sv
design/tsv_field_unescaper.sv
sim/tb_tsv_field_unescaper.sv
